### rtl/utf8d_pkg.sv
// Package for the UTF-8 stream decoder.
// Holds decoder state and result types, status codes and range limits.
// No dependencies.
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CP_MAX = 21'h10FFFF;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_t;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [1:0]     bytes_pending;
    logic [CpW-1:0] partial_code;
    logic           discard_mode;
  } dec_state_t;

  // Result produced by one byte.
  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    status_t        status;
    logic           last_of_string;
  } dec_result_t;

endpackage

### rtl/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: input register, decode step,
// decoder state and output register. Depends on utf8d_pkg and utf8d_step.
//
// Usage:
//   The input channel (in_valid/in_stall) carries one byte of a UTF-8
//   string per item, with in_string_end marking the string's final byte.
//   The output channel (out_valid/out_stall) carries one decoded item:
//   a code point with status OK, or code point 0 with status ERR for a
//   malformed, out-of-range or truncated sequence. Lead bytes and inner
//   continuation bytes produce no item; after an error nothing is produced
//   until the byte that ends the string.
// Timing:
//   An accepted byte sits in the input register while the decode step runs
//   and updates the decoder state; its result then lands in the output
//   register and is shown on out_valid. One byte is taken every cycle
//   while in_stall is low.
// Reset:
//   rst_n (synchronous, active low) empties both registers and clears the
//   pending count, partial code point and discard flag.
// Backpressure:
//   While out_stall holds a waiting result, a byte that would produce a
//   result waits in the input register, and in_stall rises; bytes that
//   produce nothing keep flowing.
module utf8_stream_decoder_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_string_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [utf8d_pkg::CpW-1:0] out_code_point,
  output logic                      out_status,
  output logic                      out_last_of_string
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // decoder state
  utf8d_pkg::dec_state_t  state_r;
  utf8d_pkg::dec_state_t  state_nxt;
  utf8d_pkg::dec_result_t res;

  // output register
  logic                      out_valid_r;
  logic [utf8d_pkg::CpW-1:0] out_cp_r;
  utf8d_pkg::status_t        out_status_r;
  logic                      out_last_r;

  logic out_free;
  logic s1_adv;
  logic in_take;

  utf8d_step u_step (
    .cur_state  (state_r),
    .data_byte  (s1_byte_r),
    .string_end (s1_end_r),
    .nxt_state  (state_nxt),
    .result     (res)
  );

  // The output slot is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Advance the held byte unless its result has nowhere to go.
  assign s1_adv   = s1_valid_r && (!res.valid || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_string_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      out_cp_r     <= res.code_point;
      out_status_r <= res.status;
      out_last_r   <= res.last_of_string;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_point     = out_cp_r;
  assign out_status         = out_status_r;
  assign out_last_of_string = out_last_r;

`ifndef SYNTHESIS
  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == utf8d_pkg::STATUS_ERR |-> out_cp_r == '0)
    else $error("error result carries a nonzero code point");

  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == utf8d_pkg::STATUS_OK |-> out_cp_r <= utf8d_pkg::CP_MAX)
    else $error("valid result above the code point range");

  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.discard_mode |-> state_r.bytes_pending == 2'd0 && state_r.partial_code == '0)
    else $error("discard mode with a sequence still open");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bytes_pending == 2'd0 |-> state_r.partial_code == '0)
    else $error("partial code left over with nothing pending");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_cp_r))
    else $error("waiting result lost or overwritten");
`endif

endmodule

### rtl/utf8d_step.sv
// One decode step of the UTF-8 stream decoder: state plus one byte in,
// next state plus an optional result out. Pure combinational logic.
// Depends on utf8d_pkg.
module utf8d_step (
  input  utf8d_pkg::dec_state_t  cur_state,
  input  logic [7:0]             data_byte,
  input  logic                   string_end,
  output utf8d_pkg::dec_state_t  nxt_state,
  output utf8d_pkg::dec_result_t result
);

  logic [utf8d_pkg::CpW-1:0] shifted;
  logic [1:0]                pend_dec;
  logic                      fail;

  assign shifted  = {cur_state.partial_code[utf8d_pkg::CpW-7:0], data_byte[5:0]};
  assign pend_dec = cur_state.bytes_pending - 2'd1;

  always_comb begin
    nxt_state             = cur_state;
    result.valid          = 1'b0;
    result.code_point     = '0;
    result.status         = utf8d_pkg::STATUS_OK;
    result.last_of_string = string_end;
    fail                  = 1'b0;

    priority if (cur_state.discard_mode) begin
      // drop bytes until the string ends
      if (string_end) begin
        nxt_state = '0;
      end
    end else if (cur_state.bytes_pending == 2'd0) begin
      priority if (!data_byte[7]) begin
        result.valid      = 1'b1;
        result.code_point = {14'd0, data_byte[6:0]};
      end else if (data_byte[7:5] == 3'b110) begin
        nxt_state.bytes_pending = 2'd1;
        nxt_state.partial_code  = {16'd0, data_byte[4:0]};
        fail                    = string_end;
      end else if (data_byte[7:4] == 4'b1110) begin
        nxt_state.bytes_pending = 2'd2;
        nxt_state.partial_code  = {17'd0, data_byte[3:0]};
        fail                    = string_end;
      end else if (data_byte[7:3] == 5'b11110) begin
        nxt_state.bytes_pending = 2'd3;
        nxt_state.partial_code  = {18'd0, data_byte[2:0]};
        fail                    = string_end;
      end else begin
        // stray continuation or invalid lead byte (F8-FF)
        fail = 1'b1;
      end
    end else if (data_byte[7:6] != 2'b10) begin
      fail = 1'b1;
    end else begin
      nxt_state.bytes_pending = pend_dec;
      if (pend_dec == 2'd0) begin
        nxt_state.partial_code = '0;
        if (shifted > utf8d_pkg::CP_MAX) begin
          fail = 1'b1;
        end else begin
          result.valid      = 1'b1;
          result.code_point = shifted;
        end
      end else begin
        nxt_state.partial_code = shifted;
        fail                   = string_end;
      end
    end

    if (fail) begin
      nxt_state.bytes_pending = 2'd0;
      nxt_state.partial_code  = '0;
      nxt_state.discard_mode  = !string_end;
      result.valid            = 1'b1;
      result.code_point       = '0;
      result.status           = utf8d_pkg::STATUS_ERR;
    end
  end

endmodule
